### rtl/core/grid_hole_fill_four_neighbour_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid hole fill block
// Shared property templates. The user supplies clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef GRID_HOLE_FILL_FOUR_NEIGHBOUR_ASSERT_SVH
`define GRID_HOLE_FILL_FOUR_NEIGHBOUR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ghf_pkg.sv
// ----------------------------------------------------------------------------
// ghf_pkg
// Shared constants for the four-neighbor grid hole fill block.
// ----------------------------------------------------------------------------
package ghf_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_ROW_WIDTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF   = 32;

  // Fixed port widths.
  localparam int PORT_SAMPLE_W = 32;
  localparam int ROW_WIDTH_W   = 11;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;

  // Quotient bits the averaging divider resolves per cycle.
  localparam int DIV_STEP_BITS = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BAD_MARKER     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MISSING_MARKER = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIX_ENABLE     = 2'd3;

  // Item opcodes.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

### rtl/core/ghf_avg_div.sv
// ----------------------------------------------------------------------------
// ghf_avg_div
// Signed divide of a neighbor sum by a count of one to four, truncating
// toward zero, resolving DIV_STEP_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module ghf_avg_div import ghf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS+1:0] sum_i,
  input  logic [2:0]             count_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] quot_o
);

  localparam int SW   = SAMPLE_BITS + 2;
  localparam int NCYC = (SW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PADW = NCYC * DIV_STEP_BITS;
  localparam int CNTW = $clog2(NCYC + 1);

  logic [PADW-1:0] work_q, work_n;
  logic [1:0]      rem_q, rem_n;
  logic [2:0]      den_q;
  logic            neg_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic [2:0]      trial;
  logic [SW-1:0]   mag;
  logic [SW-1:0]   quot_full;

  assign mag = sum_i[SW-1] ? (~sum_i + SW'(1)) : sum_i;

  // Restoring division: the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    work_n = work_q;
    rem_n  = rem_q;
    trial  = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial  = {rem_n, work_n[PADW-1]};
      work_n = {work_n[PADW-2:0], 1'b0};
      if (trial >= den_q) begin
        trial     = trial - den_q;
        work_n[0] = 1'b1;
      end
      rem_n = trial[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CNTW'(1));
      if (start_i) begin
        cnt_q <= CNTW'(NCYC);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PADW'(mag);
      rem_q  <= '0;
      den_q  <= count_i;
      neg_q  <= sum_i[SW-1];
    end else if (cnt_q != '0) begin
      work_q <= work_n;
      rem_q  <= rem_n;
    end
  end

  assign quot_full = neg_q ? (~work_q[SW-1:0] + SW'(1)) : work_q[SW-1:0];
  assign quot_o    = quot_full[SAMPLE_BITS-1:0];
  assign done_o    = done_q;

endmodule

### rtl/core/grid_hole_fill_four_neighbour.sv
// Latency: a cell leaves one row after it enters, when the cell below it is pushed.
// One item is worked on at a time: the line memories are read on the accept, then
// the item is resolved and written back; a repaired cell also waits for the averaging
// divider, and a result waits while the output register is still full.
// Reset is asynchronous and active low; the line memories are not cleared and
// need no clearing pass, since every entry is written before its read value is used.
// ----------------------------------------------------------------------------
// grid_hole_fill_four_neighbour
// Four-neighbor average hole filling on a raster-ordered grid plane, with
// one row of raw and repaired values held in line memories.
// ----------------------------------------------------------------------------
module grid_hole_fill_four_neighbour import ghf_pkg::*; #(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic [PORT_SAMPLE_W-1:0] sample_i,
  input  logic                     grid_end_i,
  // Output channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [PORT_SAMPLE_W-1:0] cell_value_o,
  output logic                     was_bad_o,
  output logic                     repaired_o,
  output logic                     plane_last_o,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int SB = SAMPLE_BITS;
  localparam int SW = SAMPLE_BITS + 2;
  localparam int CW = $clog2(MAX_ROW_WIDTH);
  localparam int PW = $clog2(MAX_ROW_WIDTH + 1);

  // The item sequencer. EVAL sees the registered memory read data.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers. The markers are kept at sample width, which is
  // the same as comparing sign-extended values.
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [SB-1:0]          bad_marker_q;
  logic [SB-1:0]          missing_marker_q;
  logic                   fix_enable_q;

  // Plane state.
  logic [CW-1:0] column_pos_q;
  logic          first_row_q;
  logic [PW-1:0] pending_q;
  logic          draining_q;
  logic [PW-1:0] tail_len_q;
  logic [SB-1:0] left_fixed_q;

  // The accepted word.
  logic          op_q;
  logic [SB-1:0] sample_q;
  logic          grid_end_q;

  // Line memories: raw samples of the held row and their repaired values.
  // The raw line is read at the current column and at its right neighbor.
  logic [SB-1:0] raw_mem   [MAX_ROW_WIDTH];
  logic [SB-1:0] fixed_mem [MAX_ROW_WIDTH];
  logic [SB-1:0] raw_c_q, raw_r_q, fix_c_q;

  // Output register.
  logic          out_valid_q;
  logic [SB-1:0] out_value_q;
  logic          out_bad_q, out_rep_q, out_last_q;

  logic          accept, cfg_we, out_free;
  logic [PW-1:0] eff_w, c_ext, c_p1, pend_m1;
  logic          is_push, old_row, right_in_row;
  logic          act, emit, last;
  logic          l_ok, r_ok, u_ok, d_ok;
  logic          l_use, r_use, u_use, d_use, raw_bad;
  logic [SW-1:0] sum_s;
  logic [2:0]    n_cnt;
  logic          rep_need, commit, div_start, div_done;
  logic [SB-1:0] div_quot, v_new;

  function automatic logic hit(input logic [SB-1:0] v, input logic [SB-1:0] b,
                               input logic [SB-1:0] m);
    return (v == b) || (v == m);
  endfunction

  // --------------------------------------------------------------------------
  // Handshakes. One word is in flight at a time; the output register lets the
  // next word in while a result still waits to be taken.
  // --------------------------------------------------------------------------
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Row width in use: zero acts as one, anything above the line depth is clamped.
  always_comb begin
    if (row_width_q == '0) begin
      eff_w = PW'(1);
    end else if (32'(row_width_q) > 32'(MAX_ROW_WIDTH)) begin
      eff_w = PW'(MAX_ROW_WIDTH);
    end else begin
      eff_w = PW'(row_width_q);
    end
  end

  // --------------------------------------------------------------------------
  // Cell resolution. Everything here is derived from registers that hold still
  // while the word is in flight, so it stays valid through DIV and WB.
  // --------------------------------------------------------------------------
  assign c_ext        = PW'(column_pos_q);
  assign c_p1         = c_ext + PW'(1);
  assign pend_m1      = pending_q - PW'(1);
  assign is_push      = (op_q == OP_PUSH);
  assign old_row      = pending_q > tail_len_q;
  assign right_in_row = c_p1 < eff_w;

  // A push while draining, and a drain while not draining or with nothing held, are
  // dropped. A push emits the cell above it once a full row is held.
  assign act  = is_push ? !draining_q : (draining_q && (pending_q != '0));
  assign emit = act && (!is_push || (pending_q >= eff_w));
  assign last = (op_q == OP_DRAIN) && (pending_q == PW'(1));

  // On the short last row the right neighbor ends at the grid end column.
  assign r_ok = (is_push || old_row) ? right_in_row : (c_p1 < tail_len_q);
  assign l_ok = (column_pos_q != '0);
  assign u_ok = !first_row_q;
  assign d_ok = is_push;

  assign raw_bad = hit(raw_c_q, bad_marker_q, missing_marker_q);
  assign l_use   = l_ok && !hit(left_fixed_q, bad_marker_q, missing_marker_q);
  assign r_use   = r_ok && !hit(raw_r_q, bad_marker_q, missing_marker_q);
  assign u_use   = u_ok && !hit(fix_c_q, bad_marker_q, missing_marker_q);
  assign d_use   = d_ok && !hit(sample_q, bad_marker_q, missing_marker_q);

  assign sum_s = (l_use ? SW'($signed(left_fixed_q)) : '0)
               + (r_use ? SW'($signed(raw_r_q))      : '0)
               + (u_use ? SW'($signed(fix_c_q))      : '0)
               + (d_use ? SW'($signed(sample_q))     : '0);
  assign n_cnt = 3'(l_use) + 3'(r_use) + 3'(u_use) + 3'(d_use);

  // A bad cell with no valid neighbor keeps its own value.
  assign rep_need = raw_bad && fix_enable_q && (n_cnt != '0);
  assign v_new    = rep_need ? div_quot : raw_c_q;

  assign div_start = (state_q == S_EVAL) && emit && rep_need;
  assign commit    = ((state_q == S_EVAL) && act && !(emit && rep_need)
                      && (!emit || out_free))
                   || ((state_q == S_WB) && out_free);

  ghf_avg_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_avg_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sum_s),
    .count_i(n_cnt),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!act) begin
          state_d = S_IDLE;
        end else if (emit && rep_need) begin
          state_d = S_DIV;
        end else if (emit && !out_free) begin
          state_d = S_WB;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_WB;
      end
      S_WB: begin
        if (out_free) state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and plane state. A row width write restarts the plane.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      row_width_q      <= ROW_WIDTH_W'(1024);
      bad_marker_q     <= '0;
      missing_marker_q <= '0;
      fix_enable_q     <= 1'b1;
      column_pos_q     <= '0;
      first_row_q      <= 1'b1;
      pending_q        <= '0;
      draining_q       <= 1'b0;
      tail_len_q       <= '0;
      left_fixed_q     <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (commit && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_ROW_WIDTH: begin
            row_width_q  <= cfg_data_i[ROW_WIDTH_W-1:0];
            column_pos_q <= '0;
            first_row_q  <= 1'b1;
            pending_q    <= '0;
            draining_q   <= 1'b0;
            tail_len_q   <= '0;
            left_fixed_q <= '0;
          end
          REG_BAD_MARKER:     bad_marker_q     <= cfg_data_i[SB-1:0];
          REG_MISSING_MARKER: missing_marker_q <= cfg_data_i[SB-1:0];
          REG_FIX_ENABLE:     fix_enable_q     <= cfg_data_i[0];
        endcase
      end else if (commit) begin
        if (!is_push) begin
          if (last) begin
            // Final cell of the plane: back to the reset plane state.
            column_pos_q <= '0;
            first_row_q  <= 1'b1;
            pending_q    <= '0;
            draining_q   <= 1'b0;
            tail_len_q   <= '0;
            left_fixed_q <= '0;
          end else begin
            pending_q    <= pend_m1;
            left_fixed_q <= v_new;
            if (old_row && (pend_m1 == tail_len_q)) begin
              // The rest of the old row is out; the short last row follows.
              column_pos_q <= '0;
              first_row_q  <= 1'b0;
            end else begin
              column_pos_q <= CW'(c_p1);
            end
          end
        end else begin
          if (emit) left_fixed_q <= v_new;
          if (emit && !right_in_row) first_row_q <= 1'b0;
          if (grid_end_q) begin
            // The cells still held are what is left of the row above after
            // this column, plus the new last row up to this column.
            draining_q   <= 1'b1;
            tail_len_q   <= c_p1;
            pending_q    <= emit ? eff_w : c_p1;
            column_pos_q <= (emit && right_in_row) ? CW'(c_p1) : '0;
          end else begin
            if (!emit) pending_q <= pending_q + PW'(1);
            column_pos_q <= right_in_row ? CW'(c_p1) : '0;
          end
        end
      end
    end
  end

  // Accepted word and output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= opcode_i;
      sample_q   <= sample_i[SB-1:0];
      grid_end_q <= grid_end_i;
    end
    if (commit && emit) begin
      out_value_q <= v_new;
      out_bad_q   <= raw_bad;
      out_rep_q   <= rep_need;
      out_last_q  <= last;
    end
  end

  // Line memories. Reads are issued with the accept; writes land at commit,
  // which always precedes the next accept, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_c_q <= raw_mem[column_pos_q];
      raw_r_q <= raw_mem[CW'(c_p1)];
      fix_c_q <= fixed_mem[column_pos_q];
    end
    if (commit && is_push) begin
      raw_mem[column_pos_q] <= sample_q;
    end
    if (commit && emit) begin
      fixed_mem[column_pos_q] <= v_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = PORT_SAMPLE_W'($signed(out_value_q));
  assign was_bad_o    = out_bad_q;
  assign repaired_o   = out_rep_q;
  assign plane_last_o = out_last_q;

endmodule

### rtl/core/ghf_chk.sv
// ----------------------------------------------------------------------------
// ghf_chk
// Port-level checks for the grid hole fill block, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_hole_fill_four_neighbour_assert.svh"

module ghf_chk import ghf_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [PORT_SAMPLE_W-1:0] cell_value_o,
  input logic                     was_bad_o,
  input logic                     repaired_o,
  input logic                     plane_last_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  // A result held against a stall stays offered.
  `GHF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output word dropped")

  // A stalled result does not change.
  `GHF_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(cell_value_o) && $stable(was_bad_o) && $stable(repaired_o) && $stable(plane_last_o), "stalled output changed")

  // One word is worked on at a time: after an accept the input stalls.
  `GHF_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second word taken early")

  // Register writes are only taken with no word in flight.
  `GHF_ASSERT_NOW(a_cfg_idle, cfg_valid_i && cfg_ready_o, !in_stall_o, "write taken while busy")

endmodule

bind grid_hole_fill_four_neighbour ghf_chk u_ghf_chk (.*);
